// File: hw/rtl/cfcrc8_pkg.sv
// Shared constants and CRC-8 helper for the command frame receiver.
package cfcrc8_pkg;

    localparam int PHASE_W = 3;
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CRC     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_READY   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRAMED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEGACY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLD = 2'd2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_RESTART = 1'b1;

    localparam int M_TDATA_W = 112;

    // CRC-8, MSB first, one byte per call
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] v;
        v = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (v[BYTE_W-1]) begin
                v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[BYTE_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/command_frame_receiver_crc8.sv
// Each accepted input word yields a registered result word in the cycle after it is accepted.
// Throughput: one word per cycle unless m_tready stalls; parser state and byte-wide
// CRC-8 update share one combinational step ahead of the state and result registers.
// Reset: synchronous, active low; parser to idle, counters and fields cleared,
// configuration to magic 0xA5, legacy limit 32, max payload 255.
module command_frame_receiver_crc8 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cfcrc8_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfcrc8_pkg::BYTE_W-1:0]     cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfcrc8_pkg::BYTE_W-1:0]     s_tdata,   // rx_byte
    input  logic                              s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // parse_phase[2:0] frame_mode[4:3] seq_number[12:5] command_code[20:13]
    // payload_length[28:21] payload_byte[36:29] payload_index[44:37]
    // crc_ok[45] frames_total[77:46] crc_errors[109:78] zero[111:110]
    output logic [cfcrc8_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast,   // frame_done
    output logic                              m_tuser    // payload_valid
);
    import cfcrc8_pkg::*;

    logic [BYTE_W-1:0]  magic_reg, legacy_lim_reg, max_payld_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [1:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0]  seq_reg, seq_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  pay_cnt_reg, pay_cnt_next;
    logic [BYTE_W-1:0]  crc_reg, crc_next;
    logic               crc_ok_reg, crc_ok_next;
    logic [CNT_W-1:0]   frame_cnt_reg, frame_cnt_next;
    logic [CNT_W-1:0]   crc_err_reg, crc_err_next;
    logic               done_next, pvalid_next;
    logic [BYTE_W-1:0]  pbyte_next, pindex_next;
    logic [BYTE_W-1:0]  crc_upd;
    logic [BYTE_W-1:0]  pay_cnt_inc;
    logic               in_fire;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg, m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign crc_upd  = crc8_byte(crc_reg, s_tdata);
    assign pay_cnt_inc = pay_cnt_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        seq_next       = seq_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        pay_cnt_next   = pay_cnt_reg;
        crc_next       = crc_reg;
        crc_ok_next    = crc_ok_reg;
        frame_cnt_next = frame_cnt_reg;
        crc_err_next   = crc_err_reg;
        done_next      = 1'b0;
        pvalid_next    = 1'b0;
        pbyte_next     = '0;
        pindex_next    = '0;
        if (s_tuser == KIND_RESTART) begin
            phase_next   = PH_IDLE;
            mode_next    = MODE_UNKNOWN;
            hdr_cnt_next = 2'd0;
            pay_cnt_next = '0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    hdr_cnt_next = 2'd0;
                    pay_cnt_next = '0;
                    if (s_tdata == magic_reg) begin
                        mode_next    = MODE_FRAMED;
                        phase_next   = PH_HEADER;
                        crc_next     = crc8_byte(CRC_INIT, s_tdata);
                        hdr_cnt_next = 2'd1;
                    end else if (s_tdata != 8'd0 && s_tdata < legacy_lim_reg) begin
                        mode_next      = MODE_LEGACY;
                        cmd_next       = s_tdata;
                        len_next       = '0;
                        crc_ok_next    = 1'b1;
                        phase_next     = PH_READY;
                        frame_cnt_next = frame_cnt_reg + 32'd1;
                        done_next      = 1'b1;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_HEADER: begin
                    crc_next = crc_upd;
                    if (hdr_cnt_reg == 2'd1) begin
                        seq_next     = s_tdata;
                        hdr_cnt_next = 2'd2;
                    end else if (hdr_cnt_reg == 2'd2) begin
                        cmd_next     = s_tdata;
                        hdr_cnt_next = 2'd3;
                    end else begin
                        len_next     = s_tdata;
                        hdr_cnt_next = 2'd0;
                        pay_cnt_next = '0;
                        if (s_tdata > max_payld_reg) begin
                            phase_next = PH_ERROR;
                        end else if (s_tdata != 8'd0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            phase_next = PH_CRC;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    crc_next     = crc_upd;
                    pvalid_next  = 1'b1;
                    pbyte_next   = s_tdata;
                    pindex_next  = pay_cnt_reg;
                    pay_cnt_next = pay_cnt_inc;
                    if (pay_cnt_inc >= len_reg) begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC: begin
                    crc_ok_next = (s_tdata == crc_reg);
                    if (s_tdata != crc_reg) begin
                        crc_err_next = crc_err_reg + 32'd1;
                    end
                    phase_next     = PH_READY;
                    frame_cnt_next = frame_cnt_reg + 32'd1;
                    done_next      = 1'b1;
                end
                PH_READY, PH_ERROR: begin
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg      <= 8'd165;
            legacy_lim_reg <= 8'd32;
            max_payld_reg  <= 8'd255;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAGIC:     magic_reg      <= cfg_wdata;
                CFG_LEGACY:    legacy_lim_reg <= cfg_wdata;
                CFG_MAX_PAYLD: max_payld_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            mode_reg      <= MODE_UNKNOWN;
            hdr_cnt_reg   <= 2'd0;
            seq_reg       <= '0;
            cmd_reg       <= '0;
            len_reg       <= '0;
            pay_cnt_reg   <= '0;
            crc_reg       <= CRC_INIT;
            crc_ok_reg    <= 1'b0;
            frame_cnt_reg <= '0;
            crc_err_reg   <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            seq_reg       <= seq_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            pay_cnt_reg   <= pay_cnt_next;
            crc_reg       <= crc_next;
            crc_ok_reg    <= crc_ok_next;
            frame_cnt_reg <= frame_cnt_next;
            crc_err_reg   <= crc_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= {2'b00, crc_err_next, frame_cnt_next, crc_ok_next,
                            pindex_next, pbyte_next, len_next, cmd_next,
                            seq_next, mode_next, phase_next};
            m_tlast_reg <= done_next;
            m_tuser_reg <= pvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == PH_READY))
        else $error("frame done without ready phase");

    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[2:0] == PH_PAYLOAD || m_tdata[2:0] == PH_CRC))
        else $error("payload word outside payload phase");

    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && frame_cnt_reg != $past(frame_cnt_reg))
            |-> $past(in_fire && done_next))
        else $error("frame counter moved without a completed frame");

endmodule

// File: dv/tb_command_frame_receiver_crc8.sv
// Self-checking testbench for the CRC-8 command frame receiver: directed and random byte streams.
module tb_command_frame_receiver_crc8;
    import cfcrc8_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] phase;
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  seq;
        logic [BYTE_W-1:0]  cmd;
        logic [BYTE_W-1:0]  len;
        logic               pvalid;
        logic [BYTE_W-1:0]  pbyte;
        logic [BYTE_W-1:0]  pidx;
        logic               crc_ok;
        logic [CNT_W-1:0]   frames;
        logic [CNT_W-1:0]   crc_errs;
    } frame_result_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0]  magic;
        logic [BYTE_W-1:0]  legacy_lim;
        logic [BYTE_W-1:0]  max_len;
        logic [PHASE_W-1:0] phase;
        logic [MODE_W-1:0]  mode;
        logic [1:0]         hdr_cnt;
        logic [BYTE_W-1:0]  seq;
        logic [BYTE_W-1:0]  cmd;
        logic [BYTE_W-1:0]  len;
        logic [BYTE_W-1:0]  pay_cnt;
        logic [BYTE_W-1:0]  crc;
        logic               crc_ok;
        logic [CNT_W-1:0]   frames;
        logic [CNT_W-1:0]   crc_errs;
        frame_result_t      expected_results[$];
        int                 errors;
        int                 checked;

        function new();
            magic      = 8'hA5;
            legacy_lim = 8'd32;
            max_len    = 8'hFF;
            phase      = PH_IDLE;
            mode       = MODE_UNKNOWN;
            hdr_cnt    = '0;
            seq        = '0;
            cmd        = '0;
            len        = '0;
            pay_cnt    = '0;
            crc        = CRC_INIT;
            crc_ok     = 1'b0;
            frames     = '0;
            crc_errs   = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        static function logic [BYTE_W-1:0] crc_next(logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] d);
            logic [BYTE_W-1:0] v;
            v = c ^ d;
            for (int i = 0; i < BYTE_W; i++) begin
                if (v[BYTE_W-1]) begin
                    v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
                end else begin
                    v = {v[BYTE_W-2:0], 1'b0};
                end
            end
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_MAGIC:     magic = val;
                CFG_LEGACY:    legacy_lim = val;
                CFG_MAX_PAYLD: max_len = val;
                default: ;
            endcase
        endfunction

        function void parse_word(logic kind, logic [BYTE_W-1:0] b);
            frame_result_t r;
            r = '0;
            if (kind == KIND_RESTART) begin
                phase   = PH_IDLE;
                mode    = MODE_UNKNOWN;
                hdr_cnt = '0;
                pay_cnt = '0;
            end else begin
                case (phase)
                    PH_IDLE: begin
                        hdr_cnt = '0;
                        pay_cnt = '0;
                        if (b == magic) begin
                            mode    = MODE_FRAMED;
                            phase   = PH_HEADER;
                            crc     = crc_next(CRC_INIT, b);
                            hdr_cnt = 2'd1;
                        end else if (b >= 8'd1 && b < legacy_lim) begin
                            mode   = MODE_LEGACY;
                            cmd    = b;
                            len    = '0;
                            crc_ok = 1'b1;
                            phase  = PH_READY;
                            frames = frames + 1;
                            r.done = 1'b1;
                        end else begin
                            phase = PH_ERROR;
                        end
                    end
                    PH_HEADER: begin
                        crc = crc_next(crc, b);
                        case (hdr_cnt)
                            2'd1: begin
                                seq     = b;
                                hdr_cnt = 2'd2;
                            end
                            2'd2: begin
                                cmd     = b;
                                hdr_cnt = 2'd3;
                            end
                            default: begin
                                len     = b;
                                hdr_cnt = '0;
                                pay_cnt = '0;
                                if (b > max_len) phase = PH_ERROR;
                                else if (b > 0)  phase = PH_PAYLOAD;
                                else             phase = PH_CRC;
                            end
                        endcase
                    end
                    PH_PAYLOAD: begin
                        crc      = crc_next(crc, b);
                        r.pvalid = 1'b1;
                        r.pbyte  = b;
                        r.pidx   = pay_cnt;
                        pay_cnt  = pay_cnt + 8'd1;
                        if (pay_cnt >= len) phase = PH_CRC;
                    end
                    PH_CRC: begin
                        crc_ok = (b == crc);
                        if (!crc_ok) crc_errs = crc_errs + 1;
                        phase  = PH_READY;
                        frames = frames + 1;
                        r.done = 1'b1;
                    end
                    PH_READY, PH_ERROR: ;
                    default: phase = PH_ERROR;
                endcase
            end
            r.phase    = phase;
            r.mode     = mode;
            r.seq      = seq;
            r.cmd      = cmd;
            r.len      = len;
            r.crc_ok   = crc_ok;
            r.frames   = frames;
            r.crc_errs = crc_errs;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                          checked, name, got, want));
        endtask

        task check_result(logic last, logic user, logic [M_TDATA_W-1:0] data);
            frame_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            compare_field("frame_done",     32'(last),         32'(want.done));
            compare_field("parse_phase",    32'(data[2:0]),    32'(want.phase));
            compare_field("frame_mode",     32'(data[4:3]),    32'(want.mode));
            compare_field("seq_number",     32'(data[12:5]),   32'(want.seq));
            compare_field("command_code",   32'(data[20:13]),  32'(want.cmd));
            compare_field("payload_length", 32'(data[28:21]),  32'(want.len));
            compare_field("payload_valid",  32'(user),         32'(want.pvalid));
            compare_field("payload_byte",   32'(data[36:29]),  32'(want.pbyte));
            compare_field("payload_index",  32'(data[44:37]),  32'(want.pidx));
            compare_field("crc_ok",         32'(data[45]),     32'(want.crc_ok));
            compare_field("frames_total",   data[77:46],       want.frames);
            compare_field("crc_errors",     data[109:78],      want.crc_errs);
            checked++;
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [BYTE_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    frame_scoreboard sb = new();
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    command_frame_receiver_crc8 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.parse_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tlast, m_tuser, m_tdata);
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_command_frame_receiver_crc8: done, errors");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [BYTE_W-1:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic restart_parser();
        send_word(KIND_RESTART, 8'($urandom_range(255)));
    endtask

    // sometimes a stray byte first; it is ignored in ready or error
    task automatic close_frame();
        if ($urandom_range(3) == 0) send_word(KIND_BYTE, 8'($urandom_range(255)));
        restart_parser();
    endtask

    // pause_at >= 0: shrink max_payload after that many payload words
    task automatic send_frame(input logic [BYTE_W-1:0] len, input bit bad_crc,
                              input int pause_at);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] flip;
        crc = frame_scoreboard::crc_next(CRC_INIT, sb.magic);
        send_word(KIND_BYTE, sb.magic);
        repeat (2) begin
            b   = 8'($urandom_range(255));
            crc = frame_scoreboard::crc_next(crc, b);
            send_word(KIND_BYTE, b);
        end
        crc = frame_scoreboard::crc_next(crc, len);
        send_word(KIND_BYTE, len);
        if (len <= sb.max_len) begin
            for (int i = 0; i < len; i++) begin
                if (i == pause_at) cfg_write(CFG_MAX_PAYLD, 8'd1);
                b   = 8'($urandom_range(255));
                crc = frame_scoreboard::crc_next(crc, b);
                send_word(KIND_BYTE, b);
            end
            flip = bad_crc ? 8'($urandom_range(1, 255)) : 8'h00;
            send_word(KIND_BYTE, crc ^ flip);
        end
    endtask

    task automatic random_phase(input int n_words);
        int target;
        int pick;
        logic [BYTE_W-1:0] len;
        target = items_sent + n_words;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                if ($urandom_range(149) == 0)
                    len = sb.max_len;
                else if ($urandom_range(9) == 0 && sb.max_len != 8'hFF)
                    len = 8'($urandom_range(sb.max_len + 1, 255));
                else
                    len = 8'($urandom_range(0, (sb.max_len < 8) ? sb.max_len : 8));
                send_frame(len, $urandom_range(4) == 0, -1);
                close_frame();
            end else if (pick < 75) begin
                if (sb.legacy_lim > 1)
                    send_word(KIND_BYTE, 8'($urandom_range(1, sb.legacy_lim - 1)));
                else
                    send_word(KIND_BYTE, 8'($urandom_range(255)));
                close_frame();
            end else if (pick < 85) begin
                send_word(KIND_BYTE, sb.magic);
                repeat ($urandom_range(0, 5)) send_word(KIND_BYTE, 8'($urandom_range(255)));
                close_frame();
            end else if (pick < 95) begin
                send_word($urandom_range(3) == 0, 8'($urandom_range(255)));
            end else begin
                restart_parser();
            end
        end
    endtask

    initial begin
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_BYTE;
        aresetn   <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // reset configuration: legacy bounds, invalid bytes, ignored bytes
        send_word(KIND_BYTE, 8'd1);
        restart_parser();
        send_word(KIND_BYTE, 8'd31);
        send_word(KIND_BYTE, 8'h07);
        restart_parser();
        send_word(KIND_BYTE, 8'd32);
        send_word(KIND_BYTE, 8'hA5);
        restart_parser();
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_RESTART, 8'hFF);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_RESTART, 8'h00);
        send_frame(8'd0, 1'b0, -1);
        restart_parser();
        send_frame(8'd2, 1'b1, -1);
        send_word(KIND_BYTE, 8'h11);
        restart_parser();
        // restart mid header, then restart while idle
        send_word(KIND_BYTE, 8'hA5);
        send_word(KIND_BYTE, 8'h12);
        restart_parser();
        restart_parser();
        // length above limit
        cfg_write(CFG_MAX_PAYLD, 8'd3);
        send_frame(8'd4, 1'b0, -1);
        restart_parser();
        send_frame(8'd3, 1'b0, -1);
        restart_parser();
        // magic inside the legacy range wins
        cfg_write(CFG_MAGIC, 8'h05);
        send_frame(8'd1, 1'b0, -1);
        restart_parser();
        // max_payload lowered while the payload is streaming
        cfg_write(CFG_MAX_PAYLD, 8'd10);
        send_frame(8'd6, 1'b0, 2);
        restart_parser();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        cfg_write(CFG_MAGIC, 8'h00);
        cfg_write(CFG_LEGACY, 8'hFF);
        cfg_write(CFG_MAX_PAYLD, 8'hFF);
        send_frame(8'hFF, 1'b0, -1);
        close_frame();
        sink_hold = 300;
        random_phase(355);

        cfg_write(CFG_MAGIC, 8'hFF);
        cfg_write(CFG_LEGACY, 8'd1);
        cfg_write(CFG_MAX_PAYLD, 8'd16);
        src_idle_pct   = 52;
        sink_stall_pct = 0;
        random_phase(355);

        cfg_write(CFG_MAGIC, 8'($urandom_range(255)));
        cfg_write(CFG_LEGACY, 8'($urandom_range(1, 255)));
        cfg_write(CFG_MAX_PAYLD, 8'($urandom_range(255)));
        src_idle_pct   = 0;
        sink_stall_pct = 52;
        random_phase(355);

        cfg_write(CFG_MAGIC, 8'h3C);
        cfg_write(CFG_LEGACY, 8'h80);
        cfg_write(CFG_MAX_PAYLD, 8'd0);
        src_idle_pct   = 26;
        sink_stall_pct = 26;
        random_phase(355);

        drain();
        if (sb.expected_results.size() != 0)
            sb.report_mismatch($sformatf("%0d expected result words never arrived",
                                         sb.expected_results.size()));
        if (sb.errors == 0) begin
            $display("tb_command_frame_receiver_crc8: done, clean");
        end else begin
            $display("tb_command_frame_receiver_crc8: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cfcrc8_pkg.sv
hw/rtl/command_frame_receiver_crc8.sv
dv/tb_command_frame_receiver_crc8.sv
